@@ rtl/fspx_pkg.sv @@
package fspx_pkg;

  localparam int RecBytes    = 12;
  localparam int QueueDepth  = 2;
  localparam int QueuePtrW   = $clog2(QueueDepth);
  localparam int QueueCntW   = $clog2(QueueDepth + 1);
  localparam int CfgIndexW   = 2;
  localparam int CfgDataW    = 5;
  localparam int PosW        = 11;

  localparam logic [7:0] TypeWindow = 8'h01;
  localparam logic [7:0] TypeRow    = 8'h02;

  localparam int MinLenWindow = 314;
  localparam int MinLenRow    = 1250;
  localparam int SlotMod      = 26;
  localparam int NumDiv       = 52;
  localparam int RowGap       = 48;
  localparam int HalfGroup    = 6;
  localparam int FloorTop     = 18;
  localparam int RoomFirst    = 5;
  localparam int RoomLast     = 12;

  localparam logic [7:0] HiMask = 8'hf0;

  localparam logic [CfgIndexW-1:0] CFG_LEVEL = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] CFG_ROOM  = CfgIndexW'(1);

  localparam logic [4:0] LevelReset = 5'd0;
  localparam logic [3:0] RoomReset  = 4'd5;

  typedef struct packed {
    logic [8:0]  base_window;
    logic [10:0] base_row;
    logic [2:0]  expect_num;
  } cfg_derived_t;

  typedef struct packed {
    logic                         row_wise;
    logic [RecBytes-1:0][7:0]     bytes;
  } pkt_rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  // slice offsets and expected packet number for a level and room
  function automatic cfg_derived_t derive(input logic [4:0] lvl, input logic [3:0] rm);
    logic [4:0]   l;
    logic [2:0]   r;
    logic [7:0]   x;
    logic [2:0]   q1;
    logic [7:0]   m;
    logic [8:0]   y;
    logic [9:0]   z;
    cfg_derived_t d;
    l = (lvl > 5'(FloorTop)) ? 5'd0 : 5'(5'(FloorTop) - lvl);
    if (rm < 4'(RoomFirst)) begin
      r = 3'd0;
    end else if (rm > 4'(RoomLast)) begin
      r = 3'(RoomLast - RoomFirst);
    end else begin
      r = 3'(rm - 4'(RoomFirst));
    end
    x  = {l, 3'b000} + {5'b00000, r};
    q1 = 3'(x >= 8'(SlotMod)) + 3'(x >= 8'(2 * SlotMod)) + 3'(x >= 8'(3 * SlotMod))
       + 3'(x >= 8'(4 * SlotMod)) + 3'(x >= 8'(5 * SlotMod));
    m  = x - 8'(q1 * 8'(SlotMod));
    d.base_window = 9'({1'b0, m} * 9'(RecBytes) + 9'd2);
    y  = {l, 4'b0000} + {5'b00000, r, 1'b0};
    d.expect_num = 3'(y >= 9'(NumDiv)) + 3'(y >= 9'(2 * NumDiv)) + 3'(y >= 9'(3 * NumDiv))
                 + 3'(y >= 9'(4 * NumDiv)) + 3'(y >= 9'(5 * NumDiv));
    z  = {l, 5'b00000} + {6'b000000, r, 1'b0};
    d.base_row = 11'({1'b0, z} * 11'd3 + 11'd2);
    return d;
  endfunction

endpackage

@@ rtl/frame_slice_pixel_extract_unit.sv @@
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in         in_valid / in_ready    data_byte, last_byte
// out      out        out_valid / out_ready  window_side, pixel_index, red, green, blue, last_pixel
//
// one byte accepted per cycle; in_ready drops only while the packet queue holds two packets
// an accepted packet is captured on its last byte, pushed into the packet queue, then loaded into out,
// then gives eight pixels, one per out request
// synchronous reset clears position, type, number, captured bytes, queue, pixel count and out valid
// out stalls fill the two-entry queue; cfg writes are taken every cycle
module frame_slice_pixel_extract_unit #(
  parameter int MAX_PACKET_BYTES = 1500
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fspx_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [fspx_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           window_side,
  output logic [1:0]                     pixel_index,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue,
  output logic                           last_pixel
);

  fspx_pkg::pkt_rec_t    push_rec;
  fspx_pkg::pkt_rec_t    head;
  fspx_pkg::queue_stat_t q_stat;
  logic                  push;
  logic                  pop;

  assign cfg_ready = 1'b1;

  fspx_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_stat    (q_stat),
    .push      (push),
    .rec       (push_rec)
  );

  fspx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  fspx_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .window_side (window_side),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_pixel  (last_pixel)
  );

`ifndef SYNTHESIS
  // both pixel orders end on the right window, last position
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last_pixel |-> window_side && pixel_index == 2'd3)
    else $error("last pixel not at right window position 3");

  assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("pixel dropped without request");

  assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("packet queue full and empty at once");

  assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("packet pushed into full queue");
`endif

endmodule

@@ rtl/fspx_front.sv @@
module fspx_front #(
  parameter int MAX_PACKET_BYTES = 1500
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [fspx_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [fspx_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  input  fspx_pkg::queue_stat_t         q_stat,
  output logic                          push,
  output fspx_pkg::pkt_rec_t            rec
);

  logic [4:0]                level;
  logic [4:0]                level_next;
  logic [3:0]                room;
  logic [3:0]                room_next;
  fspx_pkg::cfg_derived_t    derived;
  logic [fspx_pkg::PosW-1:0] byte_position;
  logic [fspx_pkg::PosW-1:0] byte_position_next;
  logic [7:0]                packet_type;
  logic [7:0]                packet_type_next;
  logic [7:0]                packet_number;
  logic [7:0]                packet_number_next;
  logic [7:0]                captured [fspx_pkg::RecBytes];
  logic [7:0]                captured_upd [fspx_pkg::RecBytes];
  logic [7:0]                captured_next [fspx_pkg::RecBytes];
  logic [fspx_pkg::PosW:0]   pos_w;
  logic [fspx_pkg::PosW:0]   off_win;
  logic [fspx_pkg::PosW:0]   off_row;
  logic                      in_buf;
  logic                      cap_en;
  logic [3:0]                cap_k;
  logic                      ok;
  logic                      accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_stat.full;

  always_comb begin
    level_next = level;
    room_next  = room;
    if (cfg_valid && cfg_index == fspx_pkg::CFG_LEVEL) begin
      level_next = cfg_data;
    end
    if (cfg_valid && cfg_index == fspx_pkg::CFG_ROOM) begin
      room_next = cfg_data[3:0];
    end
  end

  // offsets update at the same edge as the registers; derived from the next values
  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= fspx_pkg::LevelReset;
      room    <= fspx_pkg::RoomReset;
      derived <= fspx_pkg::derive(fspx_pkg::LevelReset, fspx_pkg::RoomReset);
    end else begin
      level   <= level_next;
      room    <= room_next;
      derived <= fspx_pkg::derive(level_next, room_next);
    end
  end

  assign pos_w   = {1'b0, byte_position};
  assign off_win = pos_w - {3'b000, derived.base_window};
  assign off_row = pos_w - {1'b0, derived.base_row};
  assign in_buf  = (byte_position >= fspx_pkg::PosW'(2))
                && (pos_w < (fspx_pkg::PosW + 1)'(MAX_PACKET_BYTES));

  always_comb begin
    cap_en = 1'b0;
    cap_k  = 4'd0;
    if (in_buf && packet_type == fspx_pkg::TypeWindow) begin
      if (pos_w >= {3'b000, derived.base_window}
          && off_win < (fspx_pkg::PosW + 1)'(fspx_pkg::RecBytes)) begin
        cap_en = 1'b1;
        cap_k  = off_win[3:0];
      end
    end else if (in_buf && packet_type == fspx_pkg::TypeRow) begin
      if (pos_w >= {1'b0, derived.base_row}) begin
        if (off_row < (fspx_pkg::PosW + 1)'(fspx_pkg::HalfGroup)) begin
          cap_en = 1'b1;
          cap_k  = off_row[3:0];
        end else if (off_row >= (fspx_pkg::PosW + 1)'(fspx_pkg::RowGap)
                     && off_row < (fspx_pkg::PosW + 1)'(fspx_pkg::RowGap
                                                         + fspx_pkg::HalfGroup)) begin
          cap_en = 1'b1;
          // second group lands at slots six and up
          cap_k  = 4'(off_row - (fspx_pkg::PosW + 1)'(fspx_pkg::RowGap - fspx_pkg::HalfGroup));
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < fspx_pkg::RecBytes; i++) begin
      captured_upd[i] = captured[i];
    end
    if (cap_en) begin
      captured_upd[cap_k] = data_byte;
    end
  end

  always_comb begin
    ok = 1'b0;
    if (packet_type == fspx_pkg::TypeWindow) begin
      ok = (pos_w >= (fspx_pkg::PosW + 1)'(fspx_pkg::MinLenWindow - 1))
        && (packet_number == {5'b00000, derived.expect_num});
    end else if (packet_type == fspx_pkg::TypeRow) begin
      ok = pos_w >= (fspx_pkg::PosW + 1)'(fspx_pkg::MinLenRow - 1);
    end
  end

  assign push = accept && last_byte && ok;

  always_comb begin
    rec.row_wise = (packet_type == fspx_pkg::TypeRow);
    for (int i = 0; i < fspx_pkg::RecBytes; i++) begin
      rec.bytes[i] = captured_upd[i];
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    packet_type_next   = packet_type;
    packet_number_next = packet_number;
    for (int i = 0; i < fspx_pkg::RecBytes; i++) begin
      captured_next[i] = captured[i];
    end
    if (accept) begin
      if (last_byte) begin
        byte_position_next = '0;
        packet_type_next   = '0;
        packet_number_next = '0;
        for (int i = 0; i < fspx_pkg::RecBytes; i++) begin
          captured_next[i] = '0;
        end
      end else begin
        if (byte_position == '0) begin
          packet_type_next = data_byte;
        end
        if (byte_position == fspx_pkg::PosW'(1)) begin
          packet_number_next = data_byte;
        end
        if (byte_position != '1) begin
          byte_position_next = byte_position + fspx_pkg::PosW'(1);
        end
        for (int i = 0; i < fspx_pkg::RecBytes; i++) begin
          captured_next[i] = captured_upd[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      packet_type   <= '0;
      packet_number <= '0;
      for (int i = 0; i < fspx_pkg::RecBytes; i++) begin
        captured[i] <= '0;
      end
    end else begin
      byte_position <= byte_position_next;
      packet_type   <= packet_type_next;
      packet_number <= packet_number_next;
      for (int i = 0; i < fspx_pkg::RecBytes; i++) begin
        captured[i] <= captured_next[i];
      end
    end
  end

endmodule

@@ rtl/fspx_queue.sv @@
module fspx_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  fspx_pkg::pkt_rec_t    push_rec,
  input  logic                  pop,
  output fspx_pkg::pkt_rec_t    head,
  output fspx_pkg::queue_stat_t stat
);

  fspx_pkg::pkt_rec_t              mem [fspx_pkg::QueueDepth];
  logic [fspx_pkg::QueuePtrW-1:0]  wptr;
  logic [fspx_pkg::QueuePtrW-1:0]  rptr;
  logic [fspx_pkg::QueueCntW-1:0]  count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == fspx_pkg::QueueCntW'(fspx_pkg::QueueDepth));
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == fspx_pkg::QueuePtrW'(fspx_pkg::QueueDepth - 1))
              ? '0 : wptr + fspx_pkg::QueuePtrW'(1);
      end
      if (pop) begin
        rptr <= (rptr == fspx_pkg::QueuePtrW'(fspx_pkg::QueueDepth - 1))
              ? '0 : rptr + fspx_pkg::QueuePtrW'(1);
      end
      if (push && !pop) begin
        count <= count + fspx_pkg::QueueCntW'(1);
      end else if (pop && !push) begin
        count <= count - fspx_pkg::QueueCntW'(1);
      end
    end
  end

endmodule

@@ rtl/fspx_back.sv @@
module fspx_back (
  input  logic                  clk,
  input  logic                  rst,
  input  fspx_pkg::pkt_rec_t    head,
  input  fspx_pkg::queue_stat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  window_side,
  output logic [1:0]            pixel_index,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic                  last_pixel
);

  logic [2:0] pix;
  logic       load;
  logic [3:0] idx0;
  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;
  logic [7:0] r_val;
  logic [7:0] g_val;
  logic [7:0] b_val;
  logic       side_val;
  logic [1:0] idx_val;

  assign load = !q_stat.empty && (!out_valid || out_ready);
  assign pop  = load && (pix == 3'd7);

  // three bytes feed each pixel pair
  assign idx0 = {1'b0, pix[2:1], 1'b0} + {2'b00, pix[2:1]};
  assign b0   = head.bytes[idx0];
  assign b1   = head.bytes[idx0 + 4'd1];
  assign b2   = head.bytes[idx0 + 4'd2];

  always_comb begin
    if (!pix[0]) begin
      r_val = b0 & fspx_pkg::HiMask;
      g_val = {b0[2:0], 5'b00000};
      b_val = b1 & fspx_pkg::HiMask;
    end else begin
      r_val = {b1[2:0], 5'b00000};
      g_val = b2 & fspx_pkg::HiMask;
      b_val = {b2[2:0], 5'b00000};
    end
    if (head.row_wise) begin
      side_val = pix[1];
      idx_val  = {pix[2], pix[0]};
    end else begin
      side_val = pix[2];
      idx_val  = pix[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        pix       <= pix + 3'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      window_side <= side_val;
      pixel_index <= idx_val;
      red         <= r_val;
      green       <= g_val;
      blue        <= b_val;
      last_pixel  <= (pix == 3'd7);
    end
  end

endmodule

@@ dv/tb_frame_slice_pixel_extract_unit.sv @@
`timescale 1ns / 100ps

typedef struct {
  bit       side;
  bit [1:0] idx;
  bit [7:0] red;
  bit [7:0] green;
  bit [7:0] blue;
  bit       lastp;
} pixel_t;

// mirrors the slice capture and queues the pixels each packet should give
class slice_pixel_board #(int unsigned MaxBytes = 1500);
  bit [4:0]    lvl_reg;
  bit [3:0]    room_reg;
  int unsigned at;
  bit [7:0]    kind;
  bit [7:0]    number;
  bit [7:0]    grab [fspx_pkg::RecBytes];
  pixel_t      expected [$];
  int          fails;

  function new();
    lvl_reg  = fspx_pkg::LevelReset;
    room_reg = fspx_pkg::RoomReset;
    fails    = 0;
    restart();
  endfunction

  function void restart();
    at     = 0;
    kind   = 8'h00;
    number = 8'h00;
    foreach (grab[k]) grab[k] = 8'h00;
  endfunction

  function int unsigned pending();
    return expected.size();
  endfunction

  function int unsigned floor_rows();
    int unsigned lv;
    lv = (lvl_reg > fspx_pkg::FloorTop) ? fspx_pkg::FloorTop : lvl_reg;
    return fspx_pkg::FloorTop - lv;
  endfunction

  function int unsigned room_col();
    int unsigned rm;
    rm = room_reg;
    if (rm < fspx_pkg::RoomFirst) begin
      rm = fspx_pkg::RoomFirst;
    end else if (rm > fspx_pkg::RoomLast) begin
      rm = fspx_pkg::RoomLast;
    end
    return rm - fspx_pkg::RoomFirst;
  endfunction

  function int unsigned window_number();
    return (floor_rows() * 16 + room_col() * 2) / fspx_pkg::NumDiv;
  endfunction

  function int unsigned offset_of(int unsigned k);
    int unsigned base;
    if (kind == fspx_pkg::TypeWindow) begin
      return ((floor_rows() * 8 + room_col()) % fspx_pkg::SlotMod) * fspx_pkg::RecBytes
             + 2 + k;
    end
    base = (floor_rows() * 32 + room_col() * 2) * 3 + 2;
    return (k < fspx_pkg::HalfGroup) ? base + k
                                     : base + fspx_pkg::RowGap + k - fspx_pkg::HalfGroup;
  endfunction

  function void set_reg(bit [fspx_pkg::CfgIndexW-1:0] idx, bit [fspx_pkg::CfgDataW-1:0] d);
    if (idx == fspx_pkg::CFG_LEVEL) begin
      lvl_reg = d;
    end else if (idx == fspx_pkg::CFG_ROOM) begin
      room_reg = d[3:0];
    end
  endfunction

  function void take_byte(bit [7:0] d, bit fin);
    int unsigned p;
    int unsigned len;
    bit          ok;
    pixel_t      px;
    bit [7:0]    g0;
    bit [7:0]    g1;
    bit [7:0]    g2;
    p = at;
    if (p == 0) begin
      kind = d;
    end else if (p == 1) begin
      number = d;
    end else if (p < MaxBytes && (kind == fspx_pkg::TypeWindow || kind == fspx_pkg::TypeRow))
    begin
      for (int unsigned k = 0; k < fspx_pkg::RecBytes; k++) begin
        if (offset_of(k) == p) grab[k] = d;
      end
    end
    if (!fin) begin
      if (at < ((1 << fspx_pkg::PosW) - 1)) at++;
      return;
    end
    len = (p + 1 > MaxBytes) ? MaxBytes : p + 1;
    ok = 1'b0;
    if (kind == fspx_pkg::TypeWindow) begin
      ok = (len >= fspx_pkg::MinLenWindow) && (number == window_number());
    end else if (kind == fspx_pkg::TypeRow) begin
      ok = (len >= fspx_pkg::MinLenRow);
    end
    if (ok) begin
      for (int j = 0; j < 8; j++) begin
        g0 = grab[(j / 2) * 3];
        g1 = grab[(j / 2) * 3 + 1];
        g2 = grab[(j / 2) * 3 + 2];
        // even pixels start on a high nibble, odd ones on a low nibble
        if (j % 2 == 0) begin
          px.red   = g0 & fspx_pkg::HiMask;
          px.green = {g0[2:0], 5'b00000};
          px.blue  = g1 & fspx_pkg::HiMask;
        end else begin
          px.red   = {g1[2:0], 5'b00000};
          px.green = g2 & fspx_pkg::HiMask;
          px.blue  = {g2[2:0], 5'b00000};
        end
        if (kind == fspx_pkg::TypeWindow) begin
          px.side = 1'(j / 4);
          px.idx  = 2'(j % 4);
        end else begin
          px.side = 1'((j / 2) % 2);
          px.idx  = 2'((j / 4) * 2 + (j % 2));
        end
        px.lastp = (j == 7);
        expected.push_back(px);
      end
    end
    restart();
  endfunction

  function void check_pixel(pixel_t got);
    pixel_t want;
    if (expected.size() == 0) begin
      fails++;
      if (fails <= 10) begin
        $display("unexpected pixel: side %0d idx %0d rgb %02h %02h %02h last %0d",
                 got.side, got.idx, got.red, got.green, got.blue, got.lastp);
      end
      return;
    end
    want = expected.pop_front();
    if (got.side != want.side || got.idx != want.idx || got.red != want.red ||
        got.green != want.green || got.blue != want.blue || got.lastp != want.lastp) begin
      fails++;
      if (fails <= 10) begin
        $display("pixel differs: want side %0d idx %0d rgb %02h %02h %02h last %0d",
                 want.side, want.idx, want.red, want.green, want.blue, want.lastp);
        $display("               got  side %0d idx %0d rgb %02h %02h %02h last %0d",
                 got.side, got.idx, got.red, got.green, got.blue, got.lastp);
      end
    end
  endfunction
endclass

module tb_frame_slice_pixel_extract_unit;

  localparam int unsigned MaxBytes    = 1500;
  localparam int          HoldCycles  = 2500;
  localparam int          DrainCycles = 16;
  localparam int          Limit       = 4_000_000;
  localparam int          MixCount    = 42;

  localparam logic [7:0] TypeBlank = 8'h00;
  localparam logic [7:0] TypeNext  = 8'h03;
  localparam logic [7:0] TypeJunk  = 8'hff;

  localparam logic [fspx_pkg::CfgIndexW-1:0] CFG_SPARE_LO = fspx_pkg::CfgIndexW'(2);
  localparam logic [fspx_pkg::CfgIndexW-1:0] CFG_SPARE_HI = fspx_pkg::CfgIndexW'(3);

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [fspx_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [fspx_pkg::CfgDataW-1:0]  cfg_data  = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  logic [7:0]                     data_byte = 8'h00;
  logic                           last_byte = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           window_side;
  logic [1:0]                     pixel_index;
  logic [7:0]                     red;
  logic [7:0]                     green;
  logic [7:0]                     blue;
  logic                           last_pixel;

  slice_pixel_board #(MaxBytes) sb;

  int unsigned send_idle = 27;
  int unsigned recv_idle = 88;
  int          hold_reqs = 0;
  int          cycles    = 0;

  frame_slice_pixel_extract_unit #(
    .MAX_PACKET_BYTES(MaxBytes)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .window_side(window_side),
    .pixel_index(pixel_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .last_pixel (last_pixel)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= Limit) begin
      $display("frame_slice_pixel_extract_unit: mismatch");
      $finish;
    end
  end

  // results are checked before the byte of the same edge is noted
  always @(posedge clk) begin
    pixel_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.side  = window_side;
        got.idx   = pixel_index;
        got.red   = red;
        got.green = green;
        got.blue  = blue;
        got.lastp = last_pixel;
        sb.check_pixel(got);
      end
      if (in_valid && in_ready) sb.take_byte(data_byte, last_byte);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  // receiver side, with a long hold-off whenever one is requested
  initial begin
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != served) begin
        served++;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // fill below zero means random payload bytes
  task automatic send_packet(input logic [7:0] kind, input logic [7:0] num,
                             input int unsigned len, input int fill);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      if (i == 0) begin
        b = kind;
      end else if (i == 1) begin
        b = num;
      end else if (fill < 0) begin
        b = 8'($urandom_range(255));
      end else begin
        b = 8'(fill);
      end
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic send_window(input int unsigned len, input int fill);
    send_packet(fspx_pkg::TypeWindow, 8'(sb.window_number()), len, fill);
  endtask

  task automatic cfg_put(input logic [fspx_pkg::CfgIndexW-1:0] idx,
                         input logic [fspx_pkg::CfgDataW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    // let the last accepted byte reach the scoreboard first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // a rejected packet gives nothing to wait for, so allow the pipeline to empty
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_slot(input logic [4:0] lvl, input logic [fspx_pkg::CfgDataW-1:0] rm);
    settle();
    cfg_put(fspx_pkg::CFG_LEVEL, lvl);
    cfg_put(fspx_pkg::CFG_ROOM, rm);
    if ($urandom_range(3) == 0) begin
      cfg_put($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
              fspx_pkg::CfgDataW'($urandom_range(31)));
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_slot();
    logic [4:0]                    lvl;
    logic [fspx_pkg::CfgDataW-1:0] rm;
    case ($urandom_range(4))
      0: lvl = 5'd0;
      1: lvl = 5'(fspx_pkg::FloorTop);
      2: lvl = 5'(fspx_pkg::FloorTop + 1);
      3: lvl = 5'd31;
      default: lvl = 5'($urandom_range(31));
    endcase
    case ($urandom_range(6))
      0: rm = 5'd0;
      1: rm = 5'(fspx_pkg::RoomFirst);
      2: rm = 5'(fspx_pkg::RoomLast);
      3: rm = 5'(fspx_pkg::RoomLast + 1);
      4: rm = 5'd31;
      default: rm = 5'($urandom_range(31));
    endcase
    set_slot(lvl, rm);
  endtask

  // mostly well-formed packets, the rest noise and broken ones
  task automatic mixed_packets(input int count);
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 15) random_slot();
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_window(($urandom_range(9) == 0) ? $urandom_range(1400, 1600)
                                             : $urandom_range(fspx_pkg::MinLenWindow, 420),
                    -1);
      end else if (pick < 68) begin
        send_packet(fspx_pkg::TypeRow, 8'($urandom_range(255)),
                    ($urandom_range(3) == 0) ? $urandom_range(1500, 1560)
                                             : $urandom_range(fspx_pkg::MinLenRow, 1320),
                    -1);
      end else if (pick < 80) begin
        send_packet(8'($urandom_range(255)), 8'($urandom_range(255)),
                    $urandom_range(1, 40), -1);
      end else if (pick < 90) begin
        if ($urandom_range(1)) begin
          send_packet(fspx_pkg::TypeWindow, 8'(sb.window_number() + $urandom_range(1, 255)),
                      $urandom_range(fspx_pkg::MinLenWindow, 360), -1);
        end else begin
          send_window($urandom_range(250, fspx_pkg::MinLenWindow - 1), -1);
        end
      end else begin
        send_packet(fspx_pkg::TypeRow, 8'($urandom_range(255)), $urandom_range(2, 400), -1);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // reset slot: top floor row offset, first room
    send_window(fspx_pkg::MinLenWindow, 8'hff);
    send_window(fspx_pkg::MinLenWindow - 1, -1);
    send_packet(fspx_pkg::TypeWindow, 8'(sb.window_number() + 1), fspx_pkg::MinLenWindow, -1);
    // row-wise slice lies past the buffer here, so pixels come out zero
    send_packet(fspx_pkg::TypeRow, 8'h00, fspx_pkg::MinLenRow, -1);
    send_packet(fspx_pkg::TypeRow, 8'hff, fspx_pkg::MinLenRow - 1, -1);
    send_packet(TypeBlank, 8'h05, 330, -1);
    send_packet(TypeJunk, 8'h05, 330, -1);
    send_packet(TypeNext, 8'h05, 330, -1);
    send_packet(fspx_pkg::TypeWindow, 8'h00, 1, -1);
    send_packet(fspx_pkg::TypeRow, 8'h00, 2, -1);
    // long enough to saturate the byte position
    send_packet(fspx_pkg::TypeRow, 8'h5a, 2100, -1);

    set_slot(5'(fspx_pkg::FloorTop), 5'(fspx_pkg::RoomFirst));
    send_window(fspx_pkg::MinLenWindow, 0);
    send_window(fspx_pkg::MinLenWindow + 9, -1);
    send_packet(fspx_pkg::TypeRow, 8'h00, fspx_pkg::MinLenRow, -1);

    // level and room both clamp
    set_slot(5'd31, 5'd15);
    send_window(400, -1);
    send_packet(fspx_pkg::TypeRow, 8'h33, 1260, -1);

    set_slot(5'd10, 5'd2);
    send_window(fspx_pkg::MinLenWindow, -1);
    send_window(1600, -1);

    // row-wise slice straddles the end of the buffer
    set_slot(5'd3, 5'(fspx_pkg::RoomLast));
    send_packet(fspx_pkg::TypeRow, 8'h00, MaxBytes, -1);

    mixed_packets(MixCount);

    send_idle = 88;
    recv_idle = 27;
    random_slot();
    mixed_packets(MixCount);

    send_idle = 0;
    recv_idle = 0;
    settle();
    hold_reqs++;
    repeat (4) send_window(fspx_pkg::MinLenWindow, -1);
    settle();
    mixed_packets(MixCount);

    settle();
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("frame_slice_pixel_extract_unit: match");
    end else begin
      $display("frame_slice_pixel_extract_unit: mismatch");
    end
    $finish;
  end

endmodule
